/* rtl/dstw_pkg.sv */
package dstw_pkg;

    localparam int TS_W      = 32;
    localparam int DEN_W     = 34;
    localparam int PROD_W    = 64;
    localparam int TICK_W    = 40;
    localparam int DIST_W    = 32;
    localparam int MM_NUM_W  = 23;
    localparam int MM_DEN_W  = 20;
    localparam int DIST_DEN_W = DEN_W + MM_DEN_W;
    localparam int DIST_X_W   = PROD_W + MM_NUM_W;

    // quotient bits produced by each divider, one per stage
    localparam int DIV_QBITS = 41;

    localparam logic [MM_NUM_W-1:0] MM_PER_TICK_NUM = 23'd4691763;
    localparam logic [MM_DEN_W-1:0] MM_PER_TICK_DEN = 20'd1000000;

    typedef struct packed {
        logic neg;
        logic fault;
    } t_side;

endpackage

/* rtl/dstw_div.sv */
module dstw_div
    import dstw_pkg::*;
#(
    parameter int XW = 72,
    parameter int DW = 34
) (
    input  logic                 i_clk,
    input  logic [XW-1:0]        i_dividend,
    input  logic [DW-1:0]        i_divisor,
    output logic [DIV_QBITS-1:0] o_quo,
    output logic [DW-1:0]        o_rem,
    output logic [DW-1:0]        o_divisor,
    output logic                 o_ovf
);

    logic [DW-1:0]        r_rem [0:DIV_QBITS];
    logic [DIV_QBITS-1:0] r_low [0:DIV_QBITS];
    logic [DIV_QBITS-1:0] r_quo [0:DIV_QBITS];
    logic [DW-1:0]        r_div [0:DIV_QBITS];
    logic                 r_ovf [0:DIV_QBITS];

    logic [XW-1:0] w_hi;
    logic          w_ovf;

    // quotient would need more bits than the pipeline makes
    assign w_hi  = i_dividend >> DIV_QBITS;
    assign w_ovf = w_hi >= XW'(i_divisor);

    always_ff @(posedge i_clk) begin
        r_rem[0] <= w_hi[DW-1:0];
        r_low[0] <= i_dividend[DIV_QBITS-1:0];
        r_quo[0] <= '0;
        r_div[0] <= i_divisor;
        r_ovf[0] <= w_ovf;
    end

    for (genvar g = 1; g <= DIV_QBITS; g++) begin : g_stage
        logic [DW:0]   n_trial;
        logic [DW:0]   n_diff;
        logic          n_ge;
        logic [DW-1:0] n_rem;

        always_comb begin
            n_trial = {r_rem[g-1], r_low[g-1][DIV_QBITS-1]};
            n_diff  = n_trial - {1'b0, r_div[g-1]};
            n_ge    = n_trial >= {1'b0, r_div[g-1]};
            n_rem   = n_ge ? n_diff[DW-1:0] : n_trial[DW-1:0];
        end

        always_ff @(posedge i_clk) begin
            r_rem[g] <= n_rem;
            r_low[g] <= {r_low[g-1][DIV_QBITS-2:0], 1'b0};
            r_quo[g] <= {r_quo[g-1][DIV_QBITS-2:0], n_ge};
            r_div[g] <= r_div[g-1];
            r_ovf[g] <= r_ovf[g-1];
        end
    end

    assign o_quo     = r_quo[DIV_QBITS];
    assign o_rem     = r_rem[DIV_QBITS];
    assign o_divisor = r_div[DIV_QBITS];
    assign o_ovf     = r_ovf[DIV_QBITS];

endmodule

/* rtl/ds_twr_time_of_flight_unit.sv */
// double-sided two-way ranging, time of flight and distance
//
// input: six 32-bit timestamps, transferred at a clock edge where start is
// high and busy is low; busy is high only while reset is held, so one
// exchange can be transferred every cycle
// output: o_strobe is high for one cycle with o_flight_ticks_q (ticks with
// FRAC_BITS fraction bits), o_distance_mm and o_divide_fault
// throughput: one exchange per cycle
// the pipeline is two restoring dividers that run side by side, an
// overflow check stage and then one quotient bit per stage over 41 stages,
// behind five stages that form the intervals, the products, the magnitude
// and the scaled dividend, and followed by a rounding stage and a
// saturate / sign stage
// reset clears the valid bits; exchanges in flight are dropped
// the receiver cannot hold results off, so nothing ever stalls
module ds_twr_time_of_flight_unit
    import dstw_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [TS_W-1:0]          i_tag_poll_sent,
    input  logic [TS_W-1:0]          i_tag_resp_received,
    input  logic [TS_W-1:0]          i_tag_final_sent,
    input  logic [TS_W-1:0]          i_local_poll_received,
    input  logic [TS_W-1:0]          i_local_resp_sent,
    input  logic [TS_W-1:0]          i_local_final_received,
    output logic                     o_strobe,
    output logic signed [TICK_W-1:0] o_flight_ticks_q,
    output logic signed [DIST_W-1:0] o_distance_mm,
    output logic                     o_divide_fault
);

    localparam int TX_W = PROD_W + FRAC_BITS;
    localparam int RW   = DIV_QBITS + 1;
    localparam int PP_W = TS_W + MM_NUM_W;

    logic w_take;
    assign busy   = !i_rst_n;
    assign w_take = start && !busy;

    // stage 1: intervals modulo 2^32
    logic            r_v1;
    logic [TS_W-1:0] r_ra, r_rb, r_da, r_db;
    // stage 2: products and interval sum
    logic              r_v2;
    logic [PROD_W-1:0] r_p1, r_p2;
    logic [DEN_W-1:0]  r_den2;
    // stage 3: magnitude and sign
    logic              r_v3;
    logic [PROD_W-1:0] r_mag;
    logic [DEN_W-1:0]  r_den3;
    t_side             r_side3;
    // stage 4: scaled dividends and divisor
    logic                  r_v4;
    logic [PP_W-1:0]       r_pp_lo, r_pp_hi;
    logic [TX_W-1:0]       r_xt4;
    logic [DIST_DEN_W-1:0] r_ed4;
    logic [DEN_W-1:0]      r_den4;
    t_side                 r_side4;
    // stage 5: divider inputs
    logic                  r_v5;
    logic [DIST_X_W-1:0]   r_xd5;
    logic [TX_W-1:0]       r_xt5;
    logic [DIST_DEN_W-1:0] r_ed5;
    logic [DEN_W-1:0]      r_den5;
    t_side                 r_side5;

    always_ff @(posedge i_clk) begin
        r_ra <= i_tag_resp_received - i_tag_poll_sent;
        r_rb <= i_local_final_received - i_local_resp_sent;
        r_da <= i_tag_final_sent - i_tag_resp_received;
        r_db <= i_local_resp_sent - i_local_poll_received;

        r_p1   <= PROD_W'(r_ra) * PROD_W'(r_rb);
        r_p2   <= PROD_W'(r_da) * PROD_W'(r_db);
        r_den2 <= DEN_W'(r_ra) + DEN_W'(r_rb) + DEN_W'(r_da) + DEN_W'(r_db);

        r_mag         <= (r_p1 >= r_p2) ? (r_p1 - r_p2) : (r_p2 - r_p1);
        r_side3.neg   <= r_p1 < r_p2;
        r_side3.fault <= r_den2 == '0;
        r_den3        <= r_den2;

        r_pp_lo <= PP_W'(r_mag[TS_W-1:0]) * PP_W'(MM_PER_TICK_NUM);
        r_pp_hi <= PP_W'(r_mag[PROD_W-1:TS_W]) * PP_W'(MM_PER_TICK_NUM);
        r_xt4   <= TX_W'(r_mag) << FRAC_BITS;
        r_ed4   <= DIST_DEN_W'(r_den3) * DIST_DEN_W'(MM_PER_TICK_DEN);
        r_den4  <= r_den3;
        r_side4 <= r_side3;

        r_xd5   <= DIST_X_W'(r_pp_lo) + (DIST_X_W'(r_pp_hi) << TS_W);
        r_xt5   <= r_xt4;
        r_ed5   <= r_ed4;
        r_den5  <= r_den4;
        r_side5 <= r_side4;
    end

    logic [DIV_QBITS-1:0]  w_quo_t, w_quo_d;
    logic [DEN_W-1:0]      w_rem_t, w_div_t;
    logic [DIST_DEN_W-1:0] w_rem_d, w_div_d;
    logic                  w_ovf_t, w_ovf_d;

    dstw_div #(.XW(TX_W), .DW(DEN_W)) u_div_ticks (
        .i_clk      (i_clk),
        .i_dividend (r_xt5),
        .i_divisor  (r_den5),
        .o_quo      (w_quo_t),
        .o_rem      (w_rem_t),
        .o_divisor  (w_div_t),
        .o_ovf      (w_ovf_t)
    );

    dstw_div #(.XW(DIST_X_W), .DW(DIST_DEN_W)) u_div_dist (
        .i_clk      (i_clk),
        .i_dividend (r_xd5),
        .i_divisor  (r_ed5),
        .o_quo      (w_quo_d),
        .o_rem      (w_rem_d),
        .o_divisor  (w_div_d),
        .o_ovf      (w_ovf_d)
    );

    // valid and sign travel alongside the divider stages
    logic  r_sv   [0:DIV_QBITS];
    t_side r_sside[0:DIV_QBITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            for (int i = 0; i <= DIV_QBITS; i++) r_sv[i] <= 1'b0;
        end else begin
            r_v1    <= w_take;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            r_sv[0] <= r_v5;
            for (int i = 1; i <= DIV_QBITS; i++) r_sv[i] <= r_sv[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sside[0] <= r_side5;
        for (int i = 1; i <= DIV_QBITS; i++) r_sside[i] <= r_sside[i-1];
    end

    // rounding: half or more of the divisor rounds up
    logic          r_vr;
    logic [RW-1:0] r_qt, r_qd;
    logic          r_ovt, r_ovd;
    t_side         r_sider;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr <= 1'b0;
        end else begin
            r_vr <= r_sv[DIV_QBITS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_qt <= RW'(w_quo_t) + RW'({w_rem_t, 1'b0} >= {1'b0, w_div_t});
        r_qd <= RW'(w_quo_d) + RW'({w_rem_d, 1'b0} >= {1'b0, w_div_d});
        r_ovt   <= w_ovf_t;
        r_ovd   <= w_ovf_d;
        r_sider <= r_sside[DIV_QBITS];
    end

    // saturate to the field range, then apply the sign; a zero-sum fault gives zero
    logic [RW-1:0]     n_cap_t, n_cap_d, n_mt, n_md;
    logic [TICK_W-1:0] n_ticks;
    logic [DIST_W-1:0] n_dist;

    always_comb begin
        n_cap_t = r_sider.neg ? (RW'(1) << (TICK_W - 1)) : ((RW'(1) << (TICK_W - 1)) - RW'(1));
        n_cap_d = r_sider.neg ? (RW'(1) << (DIST_W - 1)) : ((RW'(1) << (DIST_W - 1)) - RW'(1));
        n_mt    = (r_ovt || r_qt > n_cap_t) ? n_cap_t : r_qt;
        n_md    = (r_ovd || r_qd > n_cap_d) ? n_cap_d : r_qd;
        n_ticks = r_sider.neg ? (~n_mt[TICK_W-1:0] + TICK_W'(1)) : n_mt[TICK_W-1:0];
        n_dist  = r_sider.neg ? (~n_md[DIST_W-1:0] + DIST_W'(1)) : n_md[DIST_W-1:0];
        if (r_sider.fault) begin
            n_ticks = '0;
            n_dist  = '0;
        end
    end

    logic              r_strobe;
    logic [TICK_W-1:0] r_ticks;
    logic [DIST_W-1:0] r_dist;
    logic              r_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ticks <= n_ticks;
        r_dist  <= n_dist;
        r_fault <= r_sider.fault;
    end

    assign o_strobe         = r_strobe;
    assign o_flight_ticks_q = r_ticks;
    assign o_distance_mm    = r_dist;
    assign o_divide_fault   = r_fault;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import dstw_pkg::*;

    localparam int FRAC_BITS  = 8;
    localparam int LATENCY    = 49;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic signed [TICK_W-1:0] ticks;
        logic signed [DIST_W-1:0] dist_mm;
        logic                     fault;
    } t_range;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [TS_W-1:0]   i_tag_poll_sent = '0;
    logic [TS_W-1:0]   i_tag_resp_received = '0;
    logic [TS_W-1:0]   i_tag_final_sent = '0;
    logic [TS_W-1:0]   i_local_poll_received = '0;
    logic [TS_W-1:0]   i_local_resp_sent = '0;
    logic [TS_W-1:0]   i_local_final_received = '0;
    logic              o_strobe;
    logic signed [TICK_W-1:0] o_flight_ticks_q;
    logic signed [DIST_W-1:0] o_distance_mm;
    logic              o_divide_fault;

    t_range pending_ranges[$];
    int     mismatches = 0;
    int     exchanges_sent = 0;
    int     results_seen = 0;
    int     faults_seen = 0;
    int     quiet_cycles = 0;
    bit     gaps_on = 1'b1;

    always #6 i_clk = ~i_clk;

    ds_twr_time_of_flight_unit #(.FRAC_BITS(FRAC_BITS)) i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .start                  (start),
        .busy                   (busy),
        .i_tag_poll_sent        (i_tag_poll_sent),
        .i_tag_resp_received    (i_tag_resp_received),
        .i_tag_final_sent       (i_tag_final_sent),
        .i_local_poll_received  (i_local_poll_received),
        .i_local_resp_sent      (i_local_resp_sent),
        .i_local_final_received (i_local_final_received),
        .o_strobe               (o_strobe),
        .o_flight_ticks_q       (o_flight_ticks_q),
        .o_distance_mm          (o_distance_mm),
        .o_divide_fault         (o_divide_fault)
    );

    // round(mag * k / d), halves away from zero, clamped to the signed range
    function automatic logic [63:0] rounded_quotient(input logic [63:0] mag,
            input logic [31:0] k, input logic [63:0] d, input logic [63:0] lim,
            input bit neg);
        logic [127:0] num, q, r, dd, cap;
        num = {64'd0, mag} * {96'd0, k};
        dd  = {64'd0, d};
        q   = num / dd;
        r   = num % dd;
        if (r >= dd - r) begin
            q = q + 1;
        end
        cap = neg ? {64'd0, lim} + 1 : {64'd0, lim};
        if (q > cap) begin
            q = cap;
        end
        return q[63:0];
    endfunction

    function automatic t_range predict_range(input logic [31:0] poll_tx,
            input logic [31:0] resp_rx, input logic [31:0] final_tx,
            input logic [31:0] poll_rx, input logic [31:0] resp_tx,
            input logic [31:0] final_rx);
        t_range res;
        logic [31:0] ra, rb, da, db;
        logic [63:0] p1, p2, den, mag, qt, qd;
        bit neg;
        ra  = resp_rx - poll_tx;
        rb  = final_rx - resp_tx;
        da  = final_tx - resp_rx;
        db  = resp_tx - poll_rx;
        p1  = {32'd0, ra} * {32'd0, rb};
        p2  = {32'd0, da} * {32'd0, db};
        den = {32'd0, ra} + {32'd0, rb} + {32'd0, da} + {32'd0, db};
        if (den == 0) begin
            res.ticks   = '0;
            res.dist_mm = '0;
            res.fault   = 1'b1;
            return res;
        end
        neg = p1 < p2;
        mag = neg ? p2 - p1 : p1 - p2;
        qt  = rounded_quotient(mag, 32'd1 << FRAC_BITS, den, (64'd1 << 39) - 1, neg);
        qd  = rounded_quotient(mag, 32'(MM_PER_TICK_NUM), den * 64'(MM_PER_TICK_DEN),
                               (64'd1 << 31) - 1, neg);
        if (neg) begin
            qt = -qt;
            qd = -qd;
        end
        res.ticks   = qt[TICK_W-1:0];
        res.dist_mm = qd[DIST_W-1:0];
        res.fault   = 1'b0;
        return res;
    endfunction

    task automatic idle_gap();
        while (gaps_on && $urandom_range(99) < 35) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic send_timestamps(input logic [31:0] poll_tx, input logic [31:0] resp_rx,
            input logic [31:0] final_tx, input logic [31:0] poll_rx,
            input logic [31:0] resp_tx, input logic [31:0] final_rx);
        t_range exp_range;
        idle_gap();
        exp_range = predict_range(poll_tx, resp_rx, final_tx, poll_rx, resp_tx, final_rx);
        @(negedge i_clk);
        start                  <= 1'b1;
        i_tag_poll_sent        <= poll_tx;
        i_tag_resp_received    <= resp_rx;
        i_tag_final_sent       <= final_tx;
        i_local_poll_received  <= poll_rx;
        i_local_resp_sent      <= resp_tx;
        i_local_final_received <= final_rx;
        do @(posedge i_clk); while (busy);
        pending_ranges.push_back(exp_range);
        exchanges_sent++;
    endtask

    // builds the timestamps from the four intervals and two start times
    task automatic send_intervals(input logic [31:0] ra, input logic [31:0] rb,
            input logic [31:0] da, input logic [31:0] db);
        logic [31:0] t0, l0;
        t0 = $urandom;
        l0 = $urandom;
        send_timestamps(t0, t0 + ra, t0 + ra + da, l0, l0 + db, l0 + db + rb);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_ranges.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic test_directed();
        send_timestamps('0, '0, '0, '0, '0, '0);
        send_timestamps('1, '1, '1, '1, '1, '1);
        send_intervals(0, 0, 0, 0);
        send_intervals(1, 1, 0, 0);
        send_intervals(1, 1, 0, 510);
        send_intervals(0, 510, 1, 1);
        send_intervals('1, '1, 0, 0);
        send_intervals(0, 0, '1, '1);
        send_intervals('1, '1, '1, '1);
        send_intervals('1, 0, 0, 0);
        send_intervals(0, 0, 0, '1);
        send_intervals(32'h8000_0000, 32'h8000_0000, 0, 0);
        send_intervals(32'h0001_0000, 32'h0001_0000, 1, 1);
        send_intervals(3, 7, 2, 5);
        // wrapped intervals: timestamps go backward in true time
        send_timestamps(32'hFFFF_FF00, 32'h0000_0100, 32'h0000_0200,
                        32'h0000_0010, 32'hFFFF_FFF0, 32'h0000_0300);
        send_timestamps(32'h1000, 32'h0800, 32'h0400, 32'h2000, 32'h1000, 32'h0800);
        send_intervals(1000, 2000, 1990, 990);
        send_intervals(2000, 1000, 990, 1990);
        wait_drained();
    endtask

    // plausible exchanges: reply times with a small flight time on top
    task automatic test_realistic_exchanges(input int count);
        logic [31:0] tof, da, db;
        repeat (count) begin
            tof = $urandom_range(5000);
            da  = $urandom_range(32'h3FFF_FFFF);
            db  = $urandom_range(32'h3FFF_FFFF);
            if ($urandom_range(3) == 0) begin
                da = $urandom_range(100000);
                db = $urandom_range(100000);
            end
            send_intervals(db + 2 * tof + $urandom_range(3), da + 2 * tof - $urandom_range(3),
                           da, db);
        end
    endtask

    task automatic test_random_intervals(input int count);
        logic [31:0] v[4];
        repeat (count) begin
            foreach (v[i]) begin
                case ($urandom_range(3))
                    0: v[i] = $urandom_range(15);
                    1: v[i] = $urandom;
                    2: v[i] = 32'hFFFF_FFFF - $urandom_range(15);
                    default: v[i] = $urandom >> $urandom_range(31);
                endcase
            end
            send_intervals(v[0], v[1], v[2], v[3]);
        end
    endtask

    task automatic test_raw_timestamps(input int count);
        repeat (count) begin
            send_timestamps($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic test_back_to_back(input int count);
        gaps_on = 1'b0;
        test_random_intervals(count / 2);
        test_realistic_exchanges(count / 2);
        gaps_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_range exp_range;
        if (i_rst_n && start && !busy || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (pending_ranges.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: ticks %0d dist %0d fault %0b",
                             o_flight_ticks_q, o_distance_mm, o_divide_fault);
                end
            end else begin
                exp_range = pending_ranges.pop_front();
                if (exp_range.fault) begin
                    faults_seen++;
                end
                if (o_flight_ticks_q !== exp_range.ticks || o_distance_mm !== exp_range.dist_mm
                        || o_divide_fault !== exp_range.fault) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp ticks %0d dist %0d fault %0b, got %0d %0d %0b",
                                 exp_range.ticks, exp_range.dist_mm, exp_range.fault,
                                 o_flight_ticks_q, o_distance_mm, o_divide_fault);
                    end
                end
            end
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_ranges.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_realistic_exchanges(700);
        wait_drained();
        test_random_intervals(600);
        test_raw_timestamps(200);
        test_back_to_back(400);
        wait_drained();
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("%0d exchanges, %0d results (%0d zero-sum faults) checked",
                 exchanges_sent, results_seen, faults_seen);
        $display("covered wrapped, saturated, negative and half-rounded cases");
        if (mismatches == 0 && pending_ranges.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
